// ----- rtl/sme_pkg.sv -----
// ----------------------------------------------------------------------------
// SPI master byte engine package
// Shared widths, payload structs and helpers for the byte engine.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int BYTE_W    = 8;
	localparam int BIT_IDX_W = 3;
	localparam int PHASE_W   = 2;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SPI_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'b1;

	localparam logic [MODE_W-1:0] MODE_RESET  = 2'd0;
	localparam logic [BYTE_W-1:0] TICKS_RESET = 8'd1;

	// Input item function codes.
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] spi_mode;
		logic [BYTE_W-1:0] phase_ticks;
	} sme_cfg_t;

	typedef struct packed {
		logic              func;
		logic [BYTE_W-1:0] tx_byte;
		logic              hold_select;
		logic              miso_in;
	} sme_item_t;

	typedef struct packed {
		logic              sclk_out;
		logic              mosi_out;
		logic              cs_n_out;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_valid;
		logic              busy_res;
		logic              start_error;
	} sme_res_t;

	// Reload value of the delay counter; a length of zero acts as one.
	function automatic logic [BYTE_W-1:0] phase_load(input logic [BYTE_W-1:0] ticks);
		logic [BYTE_W-1:0] r;
		r = (ticks == '0) ? '0 : ticks - 1'b1;
		return r;
	endfunction

endpackage

// ----- rtl/sme_ifs.sv -----
// ----------------------------------------------------------------------------
// SPI master byte engine channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface sme_item_if import sme_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [BYTE_W-1:0] tx_byte;
	logic              hold_select;
	logic              miso_in;

	modport source (output valid, func, tx_byte, hold_select, miso_in, input ready);
	modport sink   (input valid, func, tx_byte, hold_select, miso_in, output ready);
endinterface

interface sme_res_if import sme_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              sclk_out;
	logic              mosi_out;
	logic              cs_n_out;
	logic [BYTE_W-1:0] rx_byte;
	logic              rx_valid;
	logic              busy_res;
	logic              start_error;

	modport source (output valid, sclk_out, mosi_out, cs_n_out, rx_byte, rx_valid,
		busy_res, start_error, input ready);
	modport sink   (input valid, sclk_out, mosi_out, cs_n_out, rx_byte, rx_valid,
		busy_res, start_error, output ready);
endinterface

interface sme_cfg_if import sme_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/spi_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// SPI master byte engine
// SPI master for modes 0 to 3, advanced by one tick item at a time.
// ----------------------------------------------------------------------------
// Every item on req is one tick of time; an item with func set to start also
// loads a byte to send if idle or waiting, else flags start_error. Each
// accepted item gives exactly one result item on rsp with the pin levels after
// that tick and, on the tick that ends a byte, the received byte and rx_valid.
// Register writes on cfg are taken in every cycle: index 0 is the SPI mode
// (bit 1 clock polarity, bit 0 clock phase), index 1 the phase length in ticks.
// The result of an accepted item is registered and is offered in the next
// cycle; one item is taken every cycle while rsp does not stall. The sequencer
// state and the result register sit on either side of one level of next-state
// logic, so the result register is the only buffer between the channels.
// If rsp stalls, the result register holds its item and req is taken again in
// the same cycle the held item leaves, so nothing is dropped.
// Reset puts the engine in idle with chip select high, the clock low, mode 0
// and a phase length of one tick.
// ----------------------------------------------------------------------------
module spi_master_byte_engine import sme_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	sme_item_if.sink req,
	sme_res_if.source rsp,
	sme_cfg_if.sink  cfg
);

	sme_cfg_t  cfg_regs;
	sme_item_t item;
	sme_res_t  res_d;
	sme_res_t  res_q;
	logic      in_ready;
	logic      step;

	assign cfg.ready = 1'b1;

	sme_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	assign item.func        = req.func;
	assign item.tx_byte     = req.tx_byte;
	assign item.hold_select = req.hold_select;
	assign item.miso_in     = req.miso_in;

	assign req.ready = in_ready;
	assign step      = req.valid && in_ready;

	sme_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item),
		.cfg    (cfg_regs),
		.res    (res_d)
	);

	sme_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.res_d     (res_d),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.res       (res_q)
	);

	assign rsp.sclk_out    = res_q.sclk_out;
	assign rsp.mosi_out    = res_q.mosi_out;
	assign rsp.cs_n_out    = res_q.cs_n_out;
	assign rsp.rx_byte     = res_q.rx_byte;
	assign rsp.rx_valid    = res_q.rx_valid;
	assign rsp.busy_res    = res_q.busy_res;
	assign rsp.start_error = res_q.start_error;

endmodule

// ----- rtl/sme_cfg.sv -----
// ----------------------------------------------------------------------------
// SPI master byte engine configuration registers
// Holds the SPI mode and the phase length written over the register port.
// ----------------------------------------------------------------------------
module sme_cfg import sme_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [BYTE_W-1:0]    wr_data,
	output sme_cfg_t             cfg
);

	logic [MODE_W-1:0] mode_q;
	logic [BYTE_W-1:0] ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			ticks_q <= TICKS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_SPI_MODE:    mode_q  <= wr_data[MODE_W-1:0];
				REG_PHASE_TICKS: ticks_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.spi_mode    = mode_q;
	assign cfg.phase_ticks = ticks_q;

endmodule

// ----- rtl/sme_core.sv -----
// ----------------------------------------------------------------------------
// SPI master byte engine sequencer
// Advances the transfer state by one tick for every accepted item and forms
// the pin levels and status of that item.
// ----------------------------------------------------------------------------
module sme_core import sme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  sme_item_t item,
	input  sme_cfg_t  cfg,
	output sme_res_t  res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_XFER  = 3'd2;
	localparam logic [2:0] ST_HOLD  = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;

	localparam logic [PHASE_W-1:0] PH_DRIVE  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_ACTIVE = 2'd1;
	localparam logic [PHASE_W-1:0] PH_RETURN = 2'd2;

	logic [2:0]           state_q, state_n;
	logic [BIT_IDX_W-1:0] bit_q, bit_n;
	logic [PHASE_W-1:0]   phase_q, phase_n;
	logic [BYTE_W-1:0]    dly_q, dly_n;
	logic [BYTE_W-1:0]    tx_q, tx_n;
	logic [BYTE_W-1:0]    rx_q, rx_n;
	logic                 mosi_q, mosi_n;
	logic                 keep_q, keep_n;
	logic                 done, err;
	logic [BYTE_W-1:0]    load;
	logic                 cpol, cpha;

	assign cpol = cfg.spi_mode[1];
	assign cpha = cfg.spi_mode[0];
	assign load = phase_load(cfg.phase_ticks);

	always_comb begin
		state_n = state_q;
		bit_n   = bit_q;
		phase_n = phase_q;
		dly_n   = dly_q;
		tx_n    = tx_q;
		rx_n    = rx_q;
		keep_n  = keep_q;
		done    = 1'b0;
		err     = 1'b0;

		if (item.func == FUNC_START && (state_q == ST_IDLE || state_q == ST_WAIT)) begin
			tx_n    = item.tx_byte;
			keep_n  = item.hold_select;
			rx_n    = '0;
			bit_n   = '1;
			phase_n = PH_DRIVE;
			dly_n   = load;
			state_n = (state_q == ST_IDLE) ? ST_SETUP : ST_XFER;
		end else begin
			err = (item.func == FUNC_START);
			case (state_q)
				ST_SETUP: begin
					if (dly_q != '0) begin
						dly_n = dly_q - 1'b1;
					end else begin
						state_n = ST_XFER;
						bit_n   = '1;
						phase_n = PH_DRIVE;
						dly_n   = load;
					end
				end
				ST_XFER: begin
					if (dly_q != '0) begin
						dly_n = dly_q - 1'b1;
					end else if (phase_q != PH_RETURN) begin
						phase_n = phase_q + 1'b1;
						dly_n   = load;
						// Sample on the leading edge for CPHA 0, trailing edge for CPHA 1.
						if ((phase_n == PH_ACTIVE && !cpha) || (phase_n == PH_RETURN && cpha))
							rx_n[bit_q] = rx_q[bit_q] | item.miso_in;
					end else if (bit_q != '0) begin
						bit_n   = bit_q - 1'b1;
						phase_n = PH_DRIVE;
						dly_n   = load;
					end else begin
						done    = 1'b1;
						phase_n = PH_DRIVE;
						if (keep_q) begin
							state_n = ST_WAIT;
						end else begin
							state_n = ST_HOLD;
							dly_n   = load;
						end
					end
				end
				ST_HOLD: begin
					if (dly_q != '0)
						dly_n = dly_q - 1'b1;
					else
						state_n = ST_IDLE;
				end
				default: ;
			endcase
		end

		mosi_n = (state_n == ST_XFER) ? tx_n[bit_n] : mosi_q;
	end

	always_comb begin
		res.sclk_out    = cpol ^ (state_n == ST_XFER && phase_n == PH_ACTIVE);
		res.mosi_out    = mosi_n;
		res.cs_n_out    = (state_n == ST_IDLE);
		res.rx_byte     = done ? rx_q : '0;
		res.rx_valid    = done;
		res.busy_res    = (state_n == ST_SETUP || state_n == ST_XFER || state_n == ST_HOLD);
		res.start_error = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '1;
			phase_q <= PH_DRIVE;
			dly_q   <= '0;
			tx_q    <= '0;
			rx_q    <= '0;
			mosi_q  <= 1'b0;
			keep_q  <= 1'b0;
		end else if (step) begin
			state_q <= state_n;
			bit_q   <= bit_n;
			phase_q <= phase_n;
			dly_q   <= dly_n;
			tx_q    <= tx_n;
			rx_q    <= rx_n;
			mosi_q  <= mosi_n;
			keep_q  <= keep_n;
		end
	end

endmodule

// ----- rtl/sme_out.sv -----
// ----------------------------------------------------------------------------
// SPI master byte engine result register
// Holds one result item and accepts a new input item whenever the result
// slot is empty or being taken in the same cycle.
// ----------------------------------------------------------------------------
module sme_out import sme_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sme_res_t res_d,
	output logic     out_valid,
	input  logic     out_ready,
	output sme_res_t res
);

	logic     valid_q;
	sme_res_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			res_q <= res_d;
	end

endmodule

// ----- dv/spi_master_byte_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI master byte engine testbench
// Sends tick and start items to the engine under several SPI modes and phase
// lengths, with random gaps on req and random stalls on rsp. A tick-by-tick pin
// predictor computes the pin levels, received byte and status of every result.
// Each result is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module spi_master_byte_engine_tb;
	import sme_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int          HOLD_OFF_CYCLES = 80;
	localparam int          END_PAUSE       = 8;
	localparam int          MAX_PRINTED     = 40;
	localparam int          PHASE_COUNT     = 8;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_SETUP, SEQ_XFER, SEQ_HOLD, SEQ_WAIT
	} seq_state_t;

	class spi_pin_scoreboard;
		logic [MODE_W-1:0]    mode_r;
		logic [BYTE_W-1:0]    ticks_r;
		seq_state_t           seq;
		logic [BIT_IDX_W-1:0] bit_idx;
		logic [PHASE_W-1:0]   bit_ph;
		logic [BYTE_W-1:0]    dly;
		logic [BYTE_W-1:0]    tx_sh;
		logic [BYTE_W-1:0]    rx_sh;
		logic                 mosi_q;
		logic                 keep_sel;
		sme_res_t             expected_pins_q[$];
		int                   errors;
		int                   checked;
		int                   bytes_done;
		int                   refused_starts;

		function new();
			mode_r         = MODE_RESET;
			ticks_r        = TICKS_RESET;
			seq            = SEQ_IDLE;
			bit_idx        = 3'd7;
			bit_ph         = '0;
			dly            = '0;
			tx_sh          = '0;
			rx_sh          = '0;
			mosi_q         = 1'b0;
			keep_sel       = 1'b0;
			errors         = 0;
			checked        = 0;
			bytes_done     = 0;
			refused_starts = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
			case (idx)
				REG_SPI_MODE:    mode_r = data[MODE_W-1:0];
				REG_PHASE_TICKS: ticks_r = data;
				default: ;
			endcase
		endfunction

		// A phase length of zero behaves like a length of one.
		function logic [BYTE_W-1:0] next_delay();
			return (ticks_r == '0) ? '0 : ticks_r - 8'd1;
		endfunction

		function void predict_tick(input sme_item_t it);
			sme_res_t r;
			logic     cpol;
			logic     cpha;
			r    = '0;
			cpol = mode_r[1];
			cpha = mode_r[0];
			if (it.func == FUNC_START && (seq == SEQ_IDLE || seq == SEQ_WAIT)) begin
				tx_sh    = it.tx_byte;
				keep_sel = it.hold_select;
				rx_sh    = '0;
				bit_idx  = 3'd7;
				bit_ph   = '0;
				dly      = next_delay();
				seq      = (seq == SEQ_IDLE) ? SEQ_SETUP : SEQ_XFER;
			end else begin
				if (it.func == FUNC_START)
					r.start_error = 1'b1;
				case (seq)
					SEQ_SETUP: begin
						if (dly != '0) begin
							dly = dly - 8'd1;
						end else begin
							seq     = SEQ_XFER;
							bit_idx = 3'd7;
							bit_ph  = '0;
							dly     = next_delay();
						end
					end
					SEQ_XFER: begin
						if (dly != '0) begin
							dly = dly - 8'd1;
						end else if (bit_ph < 2'd2) begin
							bit_ph = bit_ph + 2'd1;
							dly    = next_delay();
							// MISO is taken on the leading edge for CPHA 0, trailing for CPHA 1.
							if ((bit_ph == 2'd1 && !cpha) || (bit_ph == 2'd2 && cpha))
								rx_sh[bit_idx] = rx_sh[bit_idx] | it.miso_in;
						end else if (bit_idx != '0) begin
							bit_idx = bit_idx - 3'd1;
							bit_ph  = '0;
							dly     = next_delay();
						end else begin
							r.rx_valid = 1'b1;
							r.rx_byte  = rx_sh;
							bit_ph     = '0;
							if (keep_sel) begin
								seq = SEQ_WAIT;
							end else begin
								seq = SEQ_HOLD;
								dly = next_delay();
							end
						end
					end
					SEQ_HOLD: begin
						if (dly != '0)
							dly = dly - 8'd1;
						else
							seq = SEQ_IDLE;
					end
					default: ;
				endcase
			end
			if (seq == SEQ_XFER)
				mosi_q = tx_sh[bit_idx];
			r.sclk_out = cpol ^ (seq == SEQ_XFER && bit_ph == 2'd1);
			r.mosi_out = mosi_q;
			r.cs_n_out = (seq == SEQ_IDLE);
			r.busy_res = (seq == SEQ_SETUP || seq == SEQ_XFER || seq == SEQ_HOLD);
			if (r.rx_valid)
				bytes_done++;
			if (r.start_error)
				refused_starts++;
			expected_pins_q.push_back(r);
		endfunction

		task report(input string what, input logic [31:0] got_v, input logic [31:0] want_v);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("mismatch at result %0d: %s got %0h, expected %0h",
					checked, what, got_v, want_v);
		endtask

		task check_pins(input sme_res_t got);
			sme_res_t want;
			if (expected_pins_q.size() == 0) begin
				report("unexpected result item", 1, 0);
			end else begin
				want = expected_pins_q.pop_front();
				checked++;
				if (got.sclk_out !== want.sclk_out)
					report("sclk_out", 32'(got.sclk_out), 32'(want.sclk_out));
				if (got.mosi_out !== want.mosi_out)
					report("mosi_out", 32'(got.mosi_out), 32'(want.mosi_out));
				if (got.cs_n_out !== want.cs_n_out)
					report("cs_n_out", 32'(got.cs_n_out), 32'(want.cs_n_out));
				if (got.rx_byte !== want.rx_byte)
					report("rx_byte", 32'(got.rx_byte), 32'(want.rx_byte));
				if (got.rx_valid !== want.rx_valid)
					report("rx_valid", 32'(got.rx_valid), 32'(want.rx_valid));
				if (got.busy_res !== want.busy_res)
					report("busy_res", 32'(got.busy_res), 32'(want.busy_res));
				if (got.start_error !== want.start_error)
					report("start_error", 32'(got.start_error), 32'(want.start_error));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	sme_item_if req_if ();
	sme_res_if  rsp_if ();
	sme_cfg_if  cfg_if ();

	spi_master_byte_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	spi_pin_scoreboard sb;
	int                gap_pct;
	int                stall_pct;
	int                hold_off_asked;
	int                hold_off_seen;
	int                hold_off_left;
	int                reg_writes;
	int unsigned       cycle_count;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycle_count);
			$display("[spi_master_byte_engine] ERROR");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off whenever one is asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready  <= 1'b0;
			hold_off_left <= 0;
			hold_off_seen <= 0;
		end else if (hold_off_seen != hold_off_asked) begin
			hold_off_seen <= hold_off_asked;
			hold_off_left <= HOLD_OFF_CYCLES;
			rsp_if.ready  <= 1'b0;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			rsp_if.ready  <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_pins({rsp_if.sclk_out, rsp_if.mosi_out, rsp_if.cs_n_out, rsp_if.rx_byte,
				rsp_if.rx_valid, rsp_if.busy_res, rsp_if.start_error});
	end

	function automatic sme_item_t make_item(input logic func, input logic [BYTE_W-1:0] tx,
		input logic hold, input logic miso);
		sme_item_t it;
		it.func        = func;
		it.tx_byte     = tx;
		it.hold_select = hold;
		it.miso_in     = miso;
		return it;
	endfunction

	function automatic sme_item_t random_item(input int start_pct);
		return make_item(($urandom_range(99) < start_pct) ? FUNC_START : FUNC_TICK,
			BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
	endfunction

	task automatic offer_item(input sme_item_t it);
		while ($urandom_range(99) < gap_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.func        <= it.func;
		req_if.tx_byte     <= it.tx_byte;
		req_if.hold_select <= it.hold_select;
		req_if.miso_in     <= it.miso_in;
		do
			@(posedge clk);
		while (!req_if.ready);
		sb.predict_tick(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		sb.set_reg(idx, data);
		reg_writes++;
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// The sender stops offering, so no item is taken twice while results drain.
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (sb.expected_pins_q.size() != 0)
			@(posedge clk);
	endtask

	// Mostly whole byte transfers with random content; the rest is loose noise.
	// Stray starts inside a transfer exercise the refused-start path.
	task automatic run_traffic(input int budget);
		int sent;
		int xfer_len;
		int k;
		int ticks_eff;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) < 8) begin
				ticks_eff = (sb.ticks_r == '0) ? 1 : sb.ticks_r;
				offer_item(random_item(100));
				sent++;
				xfer_len = ticks_eff * 26 + $urandom_range(4);
				for (k = 0; k < xfer_len && sent < budget; k++) begin
					offer_item(random_item(4));
					sent++;
				end
			end else begin
				for (k = $urandom_range(6, 1); k > 0 && sent < budget; k--) begin
					offer_item(random_item(50));
					sent++;
				end
			end
		end
	endtask

	initial begin
		int                i;
		int                p;
		int                items_n;
		logic [MODE_W-1:0] mode_v;
		logic [BYTE_W-1:0] ticks_v;
		clk                = 1'b0;
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.func        = FUNC_TICK;
		req_if.tx_byte     = '0;
		req_if.hold_select = 1'b0;
		req_if.miso_in     = 1'b0;
		rsp_if.ready       = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = REG_SPI_MODE;
		cfg_if.data        = '0;
		gap_pct            = 0;
		stall_pct          = 0;
		hold_off_asked     = 0;
		reg_writes         = 0;
		cycle_count        = 0;
		sb                 = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_SPI_MODE, 8'd0);
		write_reg(REG_PHASE_TICKS, 8'd1);

		// One full byte that keeps chip select low, then a start straight from the
		// selected wait (no setup), then a start that arrives while busy.
		offer_item(make_item(FUNC_START, 8'hFF, 1'b1, 1'b0));
		for (i = 0; i < 25; i++)
			offer_item(make_item(FUNC_TICK, 8'h00, 1'b0, i[0]));
		offer_item(make_item(FUNC_START, 8'h00, 1'b0, 1'b1));
		offer_item(make_item(FUNC_START, 8'h5A, 1'b1, 1'b1));

		for (p = 0; p < PHASE_COUNT; p++) begin
			// Draining first means the sender has paused until every result is back;
			// the engine itself may still be mid-transfer when the registers change.
			drain_results();
			case (p)
				0: begin mode_v = 2'd0; ticks_v = 8'd1;   items_n = 160; end
				1: begin mode_v = 2'd1; ticks_v = 8'd2;   items_n = 150; end
				2: begin mode_v = 2'd2; ticks_v = 8'd1;   items_n = 140; end
				3: begin mode_v = 2'd3; ticks_v = 8'd3;   items_n = 150; end
				4: begin mode_v = 2'd1; ticks_v = 8'd0;   items_n = 140; end
				5: begin mode_v = 2'd3; ticks_v = 8'd255; items_n = 120; end
				6: begin mode_v = 2'd2; ticks_v = 8'd4;   items_n = 150; end
				default: begin mode_v = 2'd0; ticks_v = 8'd1; items_n = 140; end
			endcase
			write_reg(REG_SPI_MODE, {6'd0, mode_v});
			write_reg(REG_PHASE_TICKS, ticks_v);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 52; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 52; end
				default: begin gap_pct = 26; stall_pct = 26; end
			endcase
			if (p == 2 || p == 6)
				hold_off_asked++;
			run_traffic(items_n);
		end

		drain_results();
		repeat (END_PAUSE) @(posedge clk);

		$display("Checked %0d results across %0d register writes, all four SPI modes,",
			sb.checked, reg_writes);
		$display("phase lengths 0 to 255; %0d bytes received, %0d starts refused while busy.",
			sb.bytes_done, sb.refused_starts);
		if (sb.errors == 0) begin
			$display("[spi_master_byte_engine] OK");
		end else begin
			$display("%0d mismatches found.", sb.errors);
			$display("[spi_master_byte_engine] ERROR");
		end
		$finish;
	end

endmodule
